FILE: hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared constants, codes and controller/datapath handshake types for the
// sparse symmetric permutation block.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int MAX_ROWS_DEF     = 1024;
    localparam int MAX_NONZEROS_DEF = 8192;

    // input operation codes
    localparam logic [1:0] OP_LOAD_PERM = 2'd0;
    localparam logic [1:0] OP_LOAD_NZ   = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    // configuration register indexes
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_MATRIX_COUNT = 1'b1;

    // result kinds
    localparam logic KIND_OFFSET = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_perm;   // write permutation entry
        logic load_nz;     // append nonzero
        logic restart;     // new load: clear count, pointer, overflow
        logic latch_cfg;   // start of permute: latch rows and matrix count
        logic clr_row;     // cursor[j] = 0, j++
        logic rd_in;       // read input stores at k
        logic rd_perm;     // read permutation at row and column
        logic rd_cur;      // read cursor at mapped row
        logic upd;         // cursor increment (and scatter write)
        logic scatter;     // current pass is the scatter pass
        logic next_k;      // k++
        logic pfx_init;    // offset[0] = 0, j = 0, sum = 0
        logic pfx_rd;      // read cursor[j]
        logic pfx_wr;      // offset[j+1], cursor[j], sum update
        logic pfx_done;    // latch entry total, k = 0
        logic drain_init;  // drain pointer = 0
        logic drain_rd;    // read next result from the stores
        logic out_load;    // capture result into the output register
    } ssp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic j_done;
        logic k_done;
        logic map_ok;
        logic final_q;
        logic out_free;
    } ssp_status_t;

endpackage

FILE: hw/rtl/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer: accepts items, runs clear, count, prefix and scatter passes and
// issues drain reads.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_op,
    input  logic                 s_last,
    output logic                 s_ready,
    input  ssp_pkg::ssp_status_t sts,
    output ssp_pkg::ssp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_RD_IN, ST_RD_PERM, ST_RD_CUR, ST_UPD,
        ST_PFX_RD, ST_PFX_WR, ST_DRAIN_RD
    } state_t;

    typedef enum logic [1:0] {PH_LOAD, PH_DRAIN, PH_DONE} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   scatter_reg, scatter_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept  = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        scatter_next = scatter_reg;
        cmd          = '0;
        cmd.scatter  = scatter_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        ssp_pkg::OP_LOAD_PERM: cmd.load_perm = 1'b1;
                        ssp_pkg::OP_LOAD_NZ: begin
                            cmd.load_nz = 1'b1;
                            cmd.restart = (phase_reg != PH_LOAD);
                            phase_next  = PH_LOAD;
                            if (s_last) begin
                                cmd.latch_cfg = 1'b1;
                                scatter_next  = 1'b0;
                                state_next    = ST_CLEAR;
                            end
                        end
                        ssp_pkg::OP_READ: begin
                            if (phase_reg == PH_DRAIN) begin
                                cmd.drain_rd = 1'b1;
                                state_next   = ST_DRAIN_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (sts.j_done) begin
                    state_next = ST_RD_IN;
                end else begin
                    cmd.clr_row = 1'b1;
                end
            end
            ST_RD_IN: begin
                if (sts.k_done) begin
                    if (scatter_reg) begin
                        cmd.drain_init = 1'b1;
                        phase_next     = PH_DRAIN;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.pfx_init = 1'b1;
                        state_next   = ST_PFX_RD;
                    end
                end else begin
                    cmd.rd_in  = 1'b1;
                    state_next = ST_RD_PERM;
                end
            end
            ST_RD_PERM: begin
                cmd.rd_perm = 1'b1;
                state_next  = ST_RD_CUR;
            end
            ST_RD_CUR: begin
                if (sts.map_ok) begin
                    cmd.rd_cur = 1'b1;
                    state_next = ST_UPD;
                end else begin
                    cmd.next_k = 1'b1;
                    state_next = ST_RD_IN;
                end
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                cmd.next_k = 1'b1;
                state_next = ST_RD_IN;
            end
            ST_PFX_RD: begin
                if (sts.j_done) begin
                    cmd.pfx_done = 1'b1;
                    scatter_next = 1'b1;
                    state_next   = ST_RD_IN;
                end else begin
                    cmd.pfx_rd = 1'b1;
                    state_next = ST_PFX_WR;
                end
            end
            ST_PFX_WR: begin
                cmd.pfx_wr = 1'b1;
                state_next = ST_PFX_RD;
            end
            ST_DRAIN_RD: begin
                cmd.out_load = 1'b1;
                if (sts.final_q) begin
                    phase_next = PH_DONE;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_LOAD;
            scatter_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            scatter_reg <= scatter_next;
        end
    end

endmodule

FILE: hw/rtl/ssp_dp.sv
// ----------------------------------------------------------------------------
// ssp_dp
// Datapath: permutation, input, cursor, offset and output stores, loop
// counters, mapping logic and the output register.
// ----------------------------------------------------------------------------
module ssp_dp #(
    parameter int MAX_ROWS     = ssp_pkg::MAX_ROWS_DEF,
    parameter int MAX_NONZEROS = ssp_pkg::MAX_NONZEROS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [10:0]          cfg_data,
    input  logic [9:0]           s_index,
    input  logic [9:0]           s_perm_value,
    input  logic [9:0]           s_column,
    input  logic [63:0]          s_value_a,
    input  logic [63:0]          s_value_b,
    input  ssp_pkg::ssp_cmd_t    cmd,
    output ssp_pkg::ssp_status_t sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [13:0]          m_position,
    output logic [13:0]          m_offset_value,
    output logic [9:0]           m_new_column,
    output logic [63:0]          m_value_a,
    output logic [63:0]          m_value_b,
    output logic                 m_final,
    output logic                 m_overflow
);

    localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int NA = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int NW = $clog2(MAX_NONZEROS + 1);
    localparam int DW = $clog2(MAX_ROWS + MAX_NONZEROS + 2);

    // stores
    logic [9:0]    perm_mem    [MAX_ROWS];
    logic [9:0]    in_row_mem  [MAX_NONZEROS];
    logic [9:0]    in_col_mem  [MAX_NONZEROS];
    logic [63:0]   in_va_mem   [MAX_NONZEROS];
    logic [63:0]   in_vb_mem   [MAX_NONZEROS];
    logic [NW-1:0] cur_mem     [MAX_ROWS];
    logic [NW-1:0] off_mem     [MAX_ROWS + 1];
    logic [9:0]    out_col_mem [MAX_NONZEROS];
    logic [63:0]   out_va_mem  [MAX_NONZEROS];
    logic [63:0]   out_vb_mem  [MAX_NONZEROS];

    // configuration and control registers
    logic [10:0]   row_count_reg;
    logic [1:0]    matrix_count_reg;
    logic [RW-1:0] rows_used_reg;
    logic          two_values_reg;
    logic [NW-1:0] total_reg, total_next;
    logic          overflow_reg, overflow_next;
    logic [DW-1:0] ptr_reg;
    logic [RW-1:0] j_reg;
    logic [NW-1:0] k_reg;
    logic [NW-1:0] sum_reg;
    logic [NW-1:0] entries_reg;

    // read data registers
    logic [9:0]    in_row_q, in_col_q, pr_q, pc_q;
    logic [63:0]   in_va_q, in_vb_q;
    logic [NW-1:0] cur_q, off_q;
    logic [9:0]    col_q;
    logic [63:0]   va_q, vb_q;
    logic          kind_q, final_q;
    logic [13:0]   pos_q;

    // output register
    logic          m_valid_reg;
    logic          m_kind_reg, m_final_reg, m_ovf_reg;
    logic [13:0]   m_pos_reg, m_off_reg;
    logic [9:0]    m_col_reg;
    logic [63:0]   m_va_reg, m_vb_reg;

    logic [NW-1:0] eff_total;
    logic [9:0]    lo, hi;
    logic [RW-1:0] rows_latch;
    logic [DW-1:0] drain_total, entry_ptr;
    logic          drain_is_offset;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= 11'd1;
            matrix_count_reg <= 2'd1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                ssp_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                ssp_pkg::CFG_MATRIX_COUNT: matrix_count_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign rows_latch = (32'(row_count_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(row_count_reg);

    // nonzero count and overflow flag
    always_comb begin
        eff_total     = cmd.restart ? '0 : total_reg;
        total_next    = eff_total;
        overflow_next = cmd.restart ? 1'b0 : overflow_reg;
        if (cmd.load_nz) begin
            if (32'(eff_total) < MAX_NONZEROS) begin
                total_next = eff_total + 1'b1;
            end else begin
                overflow_next = 1'b1;
            end
        end
    end

    // mapping of the current nonzero
    assign lo = (pr_q < pc_q) ? pr_q : pc_q;
    assign hi = (pr_q < pc_q) ? pc_q : pr_q;

    assign sts.map_ok = (32'(in_row_q) < 32'(rows_used_reg)) &&
                        (32'(in_col_q) < 32'(rows_used_reg)) &&
                        (32'(hi) < 32'(rows_used_reg));
    assign sts.j_done   = (j_reg == rows_used_reg);
    assign sts.k_done   = (k_reg == total_reg);
    assign sts.final_q  = final_q;
    assign sts.out_free = !m_valid_reg || m_ready;

    // drain addressing
    assign drain_total     = DW'(rows_used_reg) + DW'(entries_reg) + 1'b1;
    assign drain_is_offset = (ptr_reg <= DW'(rows_used_reg));
    assign entry_ptr       = ptr_reg - DW'(rows_used_reg) - 1'b1;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_used_reg  <= RW'(1);
            two_values_reg <= 1'b0;
            total_reg      <= '0;
            overflow_reg   <= 1'b0;
            ptr_reg        <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            sum_reg        <= '0;
            entries_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            total_reg    <= total_next;
            overflow_reg <= overflow_next;
            if (cmd.latch_cfg) begin
                rows_used_reg  <= rows_latch;
                two_values_reg <= (matrix_count_reg >= 2'd2);
            end
            // row loop counter
            if (cmd.latch_cfg || cmd.pfx_init) begin
                j_reg <= '0;
            end else if (cmd.clr_row || cmd.pfx_wr) begin
                j_reg <= j_reg + 1'b1;
            end
            // nonzero loop counter
            if (cmd.latch_cfg || cmd.pfx_done) begin
                k_reg <= '0;
            end else if (cmd.next_k) begin
                k_reg <= k_reg + 1'b1;
            end
            // running prefix sum
            if (cmd.pfx_init) begin
                sum_reg <= '0;
            end else if (cmd.pfx_wr) begin
                sum_reg <= sum_reg + cur_q;
            end
            if (cmd.pfx_done) begin
                entries_reg <= sum_reg;
            end
            // drain pointer
            if (cmd.restart || cmd.drain_init) begin
                ptr_reg <= '0;
            end else if (cmd.drain_rd) begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            // output valid
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // permutation store
    always_ff @(posedge aclk) begin
        if (cmd.load_perm && (32'(s_index) < MAX_ROWS)) begin
            perm_mem[RA'(s_index)] <= s_perm_value;
        end
        if (cmd.rd_perm) begin
            pr_q <= perm_mem[RA'(in_row_q)];
            pc_q <= perm_mem[RA'(in_col_q)];
        end
    end

    // input stores
    always_ff @(posedge aclk) begin
        if (cmd.load_nz && (32'(eff_total) < MAX_NONZEROS)) begin
            in_row_mem[NA'(eff_total)] <= s_index;
            in_col_mem[NA'(eff_total)] <= s_column;
            in_va_mem[NA'(eff_total)]  <= s_value_a;
            in_vb_mem[NA'(eff_total)]  <= s_value_b;
        end
        if (cmd.rd_in) begin
            in_row_q <= in_row_mem[NA'(k_reg)];
            in_col_q <= in_col_mem[NA'(k_reg)];
            in_va_q  <= in_va_mem[NA'(k_reg)];
            in_vb_q  <= in_vb_mem[NA'(k_reg)];
        end
    end

    // row cursor store
    always_ff @(posedge aclk) begin
        priority if (cmd.clr_row) begin
            cur_mem[RA'(j_reg)] <= '0;
        end else if (cmd.upd) begin
            cur_mem[RA'(lo)] <= cur_q + 1'b1;
        end else if (cmd.pfx_wr) begin
            cur_mem[RA'(j_reg)] <= sum_reg;
        end else begin
        end
        if (cmd.rd_cur) begin
            cur_q <= cur_mem[RA'(lo)];
        end else if (cmd.pfx_rd) begin
            cur_q <= cur_mem[RA'(j_reg)];
        end
    end

    // row offset store
    always_ff @(posedge aclk) begin
        if (cmd.pfx_init) begin
            off_mem[0] <= '0;
        end else if (cmd.pfx_wr) begin
            off_mem[RW'(j_reg + 1'b1)] <= sum_reg + cur_q;
        end
        if (cmd.drain_rd && drain_is_offset) begin
            off_q <= off_mem[RW'(ptr_reg)];
        end
    end

    // permuted entry stores
    always_ff @(posedge aclk) begin
        if (cmd.upd && cmd.scatter) begin
            out_col_mem[NA'(cur_q)] <= hi;
            out_va_mem[NA'(cur_q)]  <= in_va_q;
            out_vb_mem[NA'(cur_q)]  <= two_values_reg ? in_vb_q : 64'd0;
        end
        if (cmd.drain_rd && !drain_is_offset) begin
            col_q <= out_col_mem[NA'(entry_ptr)];
            va_q  <= out_va_mem[NA'(entry_ptr)];
            vb_q  <= out_vb_mem[NA'(entry_ptr)];
        end
    end

    // drain item descriptor
    always_ff @(posedge aclk) begin
        if (cmd.drain_rd) begin
            kind_q  <= drain_is_offset ? ssp_pkg::KIND_OFFSET : ssp_pkg::KIND_ENTRY;
            pos_q   <= drain_is_offset ? 14'(ptr_reg) : 14'(entry_ptr);
            final_q <= ((ptr_reg + 1'b1) >= drain_total);
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg  <= kind_q;
            m_pos_reg   <= pos_q;
            m_final_reg <= final_q;
            m_ovf_reg   <= overflow_reg;
            if (kind_q == ssp_pkg::KIND_OFFSET) begin
                m_off_reg <= 14'(off_q);
                m_col_reg <= '0;
                m_va_reg  <= '0;
                m_vb_reg  <= '0;
            end else begin
                m_off_reg <= '0;
                m_col_reg <= col_q;
                m_va_reg  <= va_q;
                m_vb_reg  <= vb_q;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_position     = m_pos_reg;
    assign m_offset_value = m_off_reg;
    assign m_new_column   = m_col_reg;
    assign m_value_a      = m_va_reg;
    assign m_value_b      = m_vb_reg;
    assign m_final        = m_final_reg;
    assign m_overflow     = m_ovf_reg;

endmodule

FILE: hw/rtl/sparse_symmetric_permute.sv
// ----------------------------------------------------------------------------
// sparse_symmetric_permute
// Symmetric permutation of a lower-triangular CSR matrix (one or two value
// sets sharing a pattern).
// ----------------------------------------------------------------------------
// Load the inverse permutation with op 0 and the nonzeros in row order with
// op 1; the nonzero carrying tlast starts the permute. Loads are accepted
// back to back while the block is idle and its output register is free.
// After the last nonzero the block clears the row cursors, then runs the
// count and scatter passes (input, permutation and cursor reads and a cursor
// update per stored nonzero; one outside the row count skips the cursor
// steps) with the offset prefix sum between them; these passes are set by
// the single-port row cursor store. Each op 2 read then returns one word
// (store read, then output register): rows + 1 offset words followed by the
// permuted entries, tlast on the final one. tuser on the result marks an
// entry (1) or an offset word (0). Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module sparse_symmetric_permute #(
    parameter int MAX_ROWS     = ssp_pkg::MAX_ROWS_DEF,
    parameter int MAX_NONZEROS = ssp_pkg::MAX_NONZEROS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], index[11:2], perm_value[21:12], column[31:22],
    // value_a[95:32], value_b[159:96]
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // last
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position[13:0], offset_value[27:14], new_column[37:28],
    // out_value_a[101:38], out_value_b[165:102], overflow[166], zero[167]
    output logic [167:0] m_axis_tdata,
    output logic         m_axis_tuser,   // kind
    output logic         m_axis_tlast    // final_item
);

    ssp_pkg::ssp_cmd_t    cmd;
    ssp_pkg::ssp_status_t sts;

    logic [13:0] m_position, m_offset_value;
    logic [9:0]  m_new_column;
    logic [63:0] m_value_a, m_value_b;
    logic        m_overflow;

    assign cfg_ready = 1'b1;

    ssp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_op    (s_axis_tdata[1:0]),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ssp_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_index        (s_axis_tdata[11:2]),
        .s_perm_value   (s_axis_tdata[21:12]),
        .s_column       (s_axis_tdata[31:22]),
        .s_value_a      (s_axis_tdata[95:32]),
        .s_value_b      (s_axis_tdata[159:96]),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_kind         (m_axis_tuser),
        .m_position     (m_position),
        .m_offset_value (m_offset_value),
        .m_new_column   (m_new_column),
        .m_value_a      (m_value_a),
        .m_value_b      (m_value_b),
        .m_final        (m_axis_tlast),
        .m_overflow     (m_overflow)
    );

    // result packing
    assign m_axis_tdata = {1'b0, m_overflow, m_value_b, m_value_a, m_new_column,
                           m_offset_value, m_position};

endmodule

FILE: test/tb_sparse_symmetric_permute.sv
// ----------------------------------------------------------------------------
// tb_sparse_symmetric_permute
// Self-checking bench for the sparse symmetric permutation block.
// ----------------------------------------------------------------------------
// Loads the inverse permutation for the rows in use, then runs
// load/permute/drain jobs over several row and matrix counts: a directed set
// of corner cases, then random jobs with restarts, noise and stray reads.
// A scoreboard predicts every drained word and checks it field by field.
// Sender bursts, receiver stall patterns and one long receiver hold-off
// exercise the back-pressure paths.
// ----------------------------------------------------------------------------
module tb_sparse_symmetric_permute;

    localparam int ROWS_CAP  = ssp_pkg::MAX_ROWS_DEF;
    localparam int NZ_CAP    = ssp_pkg::MAX_NONZEROS_DEF;
    localparam int PERM_ROWS = 64;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum logic [1:0] {LOADING, DRAINING, DRAINED} job_phase_t;

    typedef struct {
        logic        kind;
        logic [13:0] position;
        logic [13:0] offset_value;
        logic [9:0]  new_column;
        logic [63:0] value_a;
        logic [63:0] value_b;
        logic        final_item;
        logic        overflow;
    } drain_word_t;

    // predictor and store of expected drain words
    class permute_scoreboard;
        logic [9:0]  perm[ROWS_CAP];
        logic [9:0]  in_row[NZ_CAP];
        logic [9:0]  in_col[NZ_CAP];
        logic [63:0] in_a[NZ_CAP];
        logic [63:0] in_b[NZ_CAP];
        int          cursor[ROWS_CAP];
        int          offs[ROWS_CAP + 1];
        logic [9:0]  out_col[NZ_CAP];
        logic [63:0] out_a[NZ_CAP];
        logic [63:0] out_b[NZ_CAP];
        int          nz_total, drain_ptr, rows_used;
        int          row_count_reg, matrix_count_reg;
        logic        two_vals, ovf;
        job_phase_t  phase;
        drain_word_t expected_words[$];
        int          errors;

        function new();
            row_count_reg = 1; matrix_count_reg = 1; rows_used = 1;
            two_vals = 0; nz_total = 0; drain_ptr = 0; ovf = 0;
            phase = LOADING; errors = 0;
            offs[1] = 0;
        endfunction

        function void write_reg(logic idx, logic [10:0] v);
            if (idx == ssp_pkg::CFG_ROW_COUNT) row_count_reg = v;
            else matrix_count_reg = v[1:0];
        endfunction

        function bit map_nz(int k, output int lo, output int hi);
            int pr, pc;
            if (in_row[k] >= rows_used || in_col[k] >= rows_used) return 0;
            pr = perm[in_row[k]];
            pc = perm[in_col[k]];
            lo = pr < pc ? pr : pc;
            hi = pr < pc ? pc : pr;
            return hi < rows_used;
        endfunction

        // count, prefix sum and stable scatter
        function void permute_matrix();
            int lo, hi, j;
            rows_used = row_count_reg > ROWS_CAP ? ROWS_CAP : row_count_reg;
            two_vals  = matrix_count_reg >= 2;
            for (int r = 0; r < rows_used; r++) cursor[r] = 0;
            for (int k = 0; k < nz_total; k++)
                if (map_nz(k, lo, hi)) cursor[lo]++;
            offs[0] = 0;
            for (int r = 0; r < rows_used; r++) offs[r + 1] = offs[r] + cursor[r];
            for (int r = 0; r < rows_used; r++) cursor[r] = offs[r];
            for (int k = 0; k < nz_total; k++) begin
                if (!map_nz(k, lo, hi)) continue;
                j = cursor[lo]++;
                out_col[j] = hi;
                out_a[j] = in_a[k];
                out_b[j] = two_vals ? in_b[k] : 64'd0;
            end
            drain_ptr = 0;
            phase = DRAINING;
        endfunction

        function int words_left();
            return phase == DRAINING ? rows_used + 1 + offs[rows_used] - drain_ptr : 0;
        endfunction

        // note one accepted input transfer
        function void note_item(logic [1:0] op, logic [9:0] idx, logic [9:0] pv,
                                logic [9:0] col, logic [63:0] a, logic [63:0] b,
                                logic last);
            drain_word_t w;
            int p, total;
            if (op == ssp_pkg::OP_LOAD_PERM) begin
                perm[idx] = pv;
            end else if (op == ssp_pkg::OP_LOAD_NZ) begin
                if (phase != LOADING) begin
                    phase = LOADING; nz_total = 0; drain_ptr = 0; ovf = 0;
                end
                if (nz_total < NZ_CAP) begin
                    in_row[nz_total] = idx; in_col[nz_total] = col;
                    in_a[nz_total] = a; in_b[nz_total] = b;
                    nz_total++;
                end else begin
                    ovf = 1;
                end
                if (last) permute_matrix();
            end else if (op == ssp_pkg::OP_READ && phase == DRAINING) begin
                total = rows_used + 1 + offs[rows_used];
                p = drain_ptr;
                w = '{default: '0};
                if (p <= rows_used) begin
                    w.kind = ssp_pkg::KIND_OFFSET;
                    w.position = p;
                    w.offset_value = offs[p];
                end else begin
                    p -= rows_used + 1;
                    w.kind = ssp_pkg::KIND_ENTRY;
                    w.position = p;
                    w.new_column = out_col[p];
                    w.value_a = out_a[p];
                    w.value_b = out_b[p];
                end
                drain_ptr++;
                if (drain_ptr >= total) begin
                    w.final_item = 1;
                    phase = DRAINED;
                end
                w.overflow = ovf;
                expected_words.push_back(w);
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // compare one drained result with the oldest expectation
        task check_word(drain_word_t got);
            drain_word_t e;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result kind %0d position %0d",
                                 got.kind, got.position));
                return;
            end
            e = expected_words.pop_front();
            cmp("kind", got.kind, e.kind);
            cmp("position", got.position, e.position);
            cmp("offset_value", got.offset_value, e.offset_value);
            cmp("new_column", got.new_column, e.new_column);
            cmp("value_a", got.value_a, e.value_a);
            cmp("value_b", got.value_b, e.value_b);
            cmp("final_item", got.final_item, e.final_item);
            cmp("overflow", got.overflow, e.overflow);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic         cfg_index = 0;
    logic [10:0]  cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    permute_scoreboard sb = new();
    int  burst_left = 0;
    bit  gaps_on = 1;
    bit  long_hold = 0;
    int  rows_now = 1;
    int  last_nz = 0;
    int  sent_items = 0;

    sparse_symmetric_permute dut (.*);

    always #2 aclk = ~aclk;

    initial begin
        #4000000;
        $display("sparse_symmetric_permute test failed");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        drain_word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            w.position     = m_axis_tdata[13:0];
            w.offset_value = m_axis_tdata[27:14];
            w.new_column   = m_axis_tdata[37:28];
            w.value_a      = m_axis_tdata[101:38];
            w.value_b      = m_axis_tdata[165:102];
            w.overflow     = m_axis_tdata[166];
            w.kind         = m_axis_tuser;
            w.final_item   = m_axis_tlast;
            sb.check_word(w);
        end
    end

    // receiver: random stall patterns, plus a long hold-off
    initial begin
        int cyc, mode;
        cyc = 0; mode = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_axis_tready = 0;
                repeat (400) @(negedge aclk);
                long_hold = 0;
            end
            if (cyc % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready = 1;
                1: m_axis_tready = $urandom_range(0, 1);
                2: m_axis_tready = ($urandom_range(0, 3) == 0);
                default: m_axis_tready = cyc[0];
            endcase
            cyc++;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [9:0] pv,
                             logic [9:0] col, logic [63:0] a, logic [63:0] b,
                             logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid = 0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tdata  = {b, a, col, pv, idx, op};
        s_axis_tlast  = last;
        s_axis_tvalid = 1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(op, idx, pv, col, a, b, last);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic send_nz(int row, int col, logic last);
        send_item(ssp_pkg::OP_LOAD_NZ, row, $urandom, col, rand64(), rand64(), last);
        last_nz++;
    endtask

    task automatic send_reads(int n);
        repeat (n) send_item(ssp_pkg::OP_READ, $urandom, $urandom, $urandom,
                             rand64(), rand64(), $urandom_range(0, 1));
    endtask

    // pause until every expected word is back and the block has gone quiet
    task automatic wait_idle();
        s_axis_tvalid = 0;
        while (sb.expected_words.size() != 0) @(negedge aclk);
        repeat (3 * rows_now + 8 * last_nz + 40) @(negedge aclk);
        last_nz = 0;
    endtask

    task automatic write_cfg(logic idx, logic [10:0] v);
        cfg_index = idx;
        cfg_data  = v;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        if (idx == ssp_pkg::CFG_ROW_COUNT) rows_now = v > ROWS_CAP ? ROWS_CAP : v;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    function automatic int pick_coord();
        if (rows_now == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, rows_now - 1);
    endfunction

    // one load/permute/drain job with random content
    task automatic random_job();
        int n;
        if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: write_cfg(ssp_pkg::CFG_ROW_COUNT, $urandom_range(0, PERM_ROWS));
                default: write_cfg(ssp_pkg::CFG_ROW_COUNT, $urandom_range(1, 16));
            endcase
            write_cfg(ssp_pkg::CFG_MATRIX_COUNT, $urandom_range(0, 3));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                send_item(ssp_pkg::OP_LOAD_PERM, $urandom, $urandom, $urandom,
                          rand64(), rand64(), $urandom_range(0, 1));
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            // noise: stray reads and spare op codes while loading
            if ($urandom_range(0, 15) == 0)
                send_item($urandom_range(0, 1) ? ssp_pkg::OP_READ : OP_SPARE, $urandom,
                          $urandom, $urandom, rand64(), rand64(), 1);
            send_nz(pick_coord(), pick_coord(), i == n - 1);
        end
        // sometimes break off the drain early and let the next job restart
        if ($urandom_range(0, 7) == 0)
            send_reads($urandom_range(0, sb.words_left()));
        else
            send_reads(sb.words_left() + $urandom_range(0, 2));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // inverse permutation for the rows in use: reversal on the first 8 rows
        write_cfg(ssp_pkg::CFG_ROW_COUNT, 8);
        write_cfg(ssp_pkg::CFG_MATRIX_COUNT, 2);
        for (int i = 0; i < PERM_ROWS; i++)
            send_item(ssp_pkg::OP_LOAD_PERM, i, i < 8 ? 7 - i : $urandom, $urandom,
                      rand64(), rand64(), $urandom_range(0, 1));
        send_item(ssp_pkg::OP_LOAD_PERM, ROWS_CAP - 1, $urandom, $urandom,
                  rand64(), rand64(), 0);

        // directed corner cases
        send_item(ssp_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_SPARE, 10'h3ff, 10'h3ff, 10'h3ff, '1, '1, 1);
        send_item(ssp_pkg::OP_LOAD_NZ, 0, 0, 0, 64'd0, '1, 0);
        send_item(ssp_pkg::OP_LOAD_NZ, 7, 10'h3ff, 7, '1, 64'd0, 0);
        send_nz(7, 0, 0);
        send_nz(3, 5, 0);
        send_nz(9, 1, 0);
        send_nz(2, 1023, 0);
        send_nz(5, 2, 1);
        send_reads(sb.words_left() + 2);
        // restart part way through a drain, with a permutation write in it
        send_nz(1, 1, 0);
        send_nz(6, 4, 1);
        send_reads(3);
        send_item(ssp_pkg::OP_LOAD_PERM, 3, 3, 0, 0, 0, 0);
        send_nz(4, 3, 1);
        long_hold = 1;
        send_reads(sb.words_left());

        // no rows at all, saturated rows, matrix counts 0 and 3
        wait_idle();
        write_cfg(ssp_pkg::CFG_ROW_COUNT, 0);
        write_cfg(ssp_pkg::CFG_MATRIX_COUNT, 0);
        send_nz(0, 0, 1);
        send_reads(2);
        wait_idle();
        write_cfg(ssp_pkg::CFG_ROW_COUNT, 2047);
        write_cfg(ssp_pkg::CFG_MATRIX_COUNT, 3);
        send_nz(1023, 1023, 0);
        send_nz(0, 1023, 1);
        send_reads(6);
        wait_idle();
        write_cfg(ssp_pkg::CFG_ROW_COUNT, 1);
        send_nz(0, 0, 1);
        send_reads(sb.words_left());

        // random jobs, some without sender gaps
        while (sent_items < 1200) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            random_job();
        end
        gaps_on = 1;

        s_axis_tvalid = 0;
        for (int i = 0; i < 200000 && sb.expected_words.size() != 0; i++)
            @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (sb.expected_words.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_words.size()));
        if (sb.errors == 0)
            $display("sparse_symmetric_permute test passed");
        else
            $display("sparse_symmetric_permute test failed");
        $finish;
    end

endmodule

FILE: sparse_symmetric_permute.f
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_ctrl.sv
hw/rtl/ssp_dp.sv
hw/rtl/sparse_symmetric_permute.sv
test/tb_sparse_symmetric_permute.sv
